// ===== hw/rtl/sha256_pkg.sv =====
package sha256_pkg;

  typedef logic [31:0] word_t;

  localparam int unsigned NumRounds = 64;
  localparam int unsigned NumHashWords = 8;

  localparam logic [7:0] PadMarker = 8'h80;

  localparam word_t HashInit [NumHashWords] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t RoundK [NumRounds] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic word_t rotr(input word_t x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic word_t big_sig0(input word_t x);
    return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic word_t big_sig1(input word_t x);
    return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic word_t small_sig0(input word_t x);
    return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t small_sig1(input word_t x);
    return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

endpackage

// ===== hw/rtl/sha256_hash_engine.sv =====
// byte-serial sha-256 engine
// input channel (in_valid_i / in_ready_o): one beat carries data_byte_i, has_byte_i
// and is_last_i. a beat with has_byte_i low and is_last_i low changes nothing.
// output channel (out_valid_o / out_ready_i): eight beats per finished message,
// digest_word_o most significant word first, word_index_o 0..7, last_word_o on 7.
// input: a byte beat is taken whenever in_ready_o is high. the beat that fills a
// 64-byte block starts a compression (64 rounds through one shared round unit,
// then the hash update), during which in_ready_o is low.
// finishing: after the is_last beat the padding bytes are shifted into the block
// one per cycle (64 minus the bytes held, plus 64 more when a second block is
// needed), each block is then compressed, and the digest follows as 8 beats.
// in_ready_o stays low from the is_last beat until the eighth digest beat is taken.
// a stalled receiver simply holds the digest beat; nothing else moves meanwhile.
// reset loads the initial hash values and clears byte and length counters; the
// block and round registers hold no meaningful value until written.
module sha256_hash_engine (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        has_byte_i,
  input  logic        is_last_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        last_word_o
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StPad  = 3'd1;
  localparam logic [2:0] StComp = 3'd2;
  localparam logic [2:0] StFadd = 3'd3;
  localparam logic [2:0] StOut  = 3'd4;

  logic [2:0]  st_q, st_d;
  logic [5:0]  fill_q, fill_d;
  logic [60:0] len_q, len_d;
  logic [5:0]  rnd_q, rnd_d;
  logic [2:0]  oidx_q, oidx_d;
  logic        fin_q, fin_d;
  logic        mark_q, mark_d;
  logic        zero_q, zero_d;
  logic        done_q, done_d;
  logic [511:0] blk_q, blk_d;
  sha256_pkg::word_t h_q [sha256_pkg::NumHashWords];
  sha256_pkg::word_t h_d [sha256_pkg::NumHashWords];
  sha256_pkg::word_t v_q [sha256_pkg::NumHashWords];
  sha256_pkg::word_t v_d [sha256_pkg::NumHashWords];

  sha256_pkg::word_t w_top, w_new, t1, t2, ch, mj;
  logic [63:0] len_bits;
  logic [7:0]  len_byte;
  logic [7:0]  pad_byte;

  // schedule words sit in the block shift line, oldest at the top
  assign w_top = blk_q[511:480];
  assign w_new = w_top + sha256_pkg::small_sig0(blk_q[479:448]) + blk_q[223:192]
               + sha256_pkg::small_sig1(blk_q[63:32]);

  assign ch = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
  assign mj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
  assign t1 = v_q[7] + sha256_pkg::big_sig1(v_q[4]) + ch + sha256_pkg::RoundK[rnd_q]
            + w_top;
  assign t2 = sha256_pkg::big_sig0(v_q[0]) + mj;

  assign len_bits = {len_q, 3'b000};
  assign len_byte = len_bits[{~fill_q[2:0], 3'b000} +: 8];

  always_comb begin
    if (!mark_q) begin
      pad_byte = sha256_pkg::PadMarker;
    end else if (fill_q[5:3] == 3'h7 && !zero_q) begin
      pad_byte = len_byte;
    end else begin
      pad_byte = '0;
    end
  end

  always_comb begin
    st_d   = st_q;
    fill_d = fill_q;
    len_d  = len_q;
    rnd_d  = rnd_q;
    oidx_d = oidx_q;
    fin_d  = fin_q;
    mark_d = mark_q;
    zero_d = zero_q;
    done_d = done_q;
    blk_d  = blk_q;
    h_d    = h_q;
    v_d    = v_q;

    case (st_q)
      StIdle: begin
        if (in_valid_i) begin
          if (has_byte_i) begin
            blk_d  = {blk_q[503:0], data_byte_i};
            fill_d = fill_q + 6'd1;
            len_d  = len_q + 61'd1;
            fin_d  = is_last_i;
            if (&fill_q) begin
              st_d  = StComp;
              rnd_d = '0;
              v_d   = h_q;
            end else if (is_last_i) begin
              st_d = StPad;
            end
          end else if (is_last_i) begin
            fin_d = 1'b1;
            st_d  = StPad;
          end
        end
      end
      StPad: begin
        blk_d  = {blk_q[503:0], pad_byte};
        fill_d = fill_q + 6'd1;
        if (!mark_q) begin
          mark_d = 1'b1;
          // marker landed in the length field: length goes in a second block
          zero_d = (fill_q[5:3] == 3'h7);
        end
        if (&fill_q) begin
          done_d = mark_q && !zero_q;
          st_d   = StComp;
          rnd_d  = '0;
          v_d    = h_q;
        end
      end
      StComp: begin
        v_d[7] = v_q[6];
        v_d[6] = v_q[5];
        v_d[5] = v_q[4];
        v_d[4] = v_q[3] + t1;
        v_d[3] = v_q[2];
        v_d[2] = v_q[1];
        v_d[1] = v_q[0];
        v_d[0] = t1 + t2;
        blk_d  = {blk_q[479:0], w_new};
        rnd_d  = rnd_q + 6'd1;
        if (&rnd_q) begin
          st_d = StFadd;
        end
      end
      StFadd: begin
        for (int i = 0; i < sha256_pkg::NumHashWords; i++) begin
          h_d[i] = h_q[i] + v_q[i];
        end
        if (!fin_q) begin
          st_d = StIdle;
        end else if (done_q) begin
          st_d   = StOut;
          oidx_d = '0;
        end else begin
          st_d   = StPad;
          zero_d = 1'b0;
        end
      end
      StOut: begin
        if (out_ready_i) begin
          oidx_d = oidx_q + 3'd1;
          if (&oidx_q) begin
            st_d   = StIdle;
            h_d    = sha256_pkg::HashInit;
            len_d  = '0;
            fill_d = '0;
            fin_d  = 1'b0;
            mark_d = 1'b0;
            zero_d = 1'b0;
            done_d = 1'b0;
          end
        end
      end
      default: begin
        st_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= StIdle;
      fill_q <= '0;
      len_q  <= '0;
      rnd_q  <= '0;
      oidx_q <= '0;
      fin_q  <= 1'b0;
      mark_q <= 1'b0;
      zero_q <= 1'b0;
      done_q <= 1'b0;
      h_q    <= sha256_pkg::HashInit;
    end else begin
      st_q   <= st_d;
      fill_q <= fill_d;
      len_q  <= len_d;
      rnd_q  <= rnd_d;
      oidx_q <= oidx_d;
      fin_q  <= fin_d;
      mark_q <= mark_d;
      zero_q <= zero_d;
      done_q <= done_d;
      h_q    <= h_d;
    end
  end

  always_ff @(posedge clk_i) begin
    blk_q <= blk_d;
    v_q   <= v_d;
  end

  assign in_ready_o    = (st_q == StIdle);
  assign out_valid_o   = (st_q == StOut);
  assign digest_word_o = h_q[oidx_q];
  assign word_index_o  = oidx_q;
  assign last_word_o   = &oidx_q;

`ifndef NO_ASSERTIONS
  a_no_input_while_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o)
    else $error("input taken while digest pending");

  a_block_full_in_comp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == StComp) |-> (fill_q == '0))
    else $error("compression started on a partial block");

  a_done_needs_marker: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (mark_q && fin_q))
    else $error("length block finished without pad marker");

  a_restart_after_digest: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && last_word_o) |=>
      (in_ready_o && fill_q == '0 && len_q == '0 && h_q[0] == sha256_pkg::HashInit[0]))
    else $error("engine not back to initial state after digest");
`endif

endmodule

// ===== dv/sha256_hash_engine_tb.sv =====
module sha256_hash_engine_tb;

  localparam int unsigned StallLimit = 3000;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned DrainCycles = 300;

  localparam logic [31:0] IvWords [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] KWords [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        last;
  } digest_beat_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  data_byte_i = 8'h00;
  logic        has_byte_i = 1'b0;
  logic        is_last_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [31:0] digest_word_o;
  logic [2:0]  word_index_o;
  logic        last_word_o;

  // running hash of the message in flight
  logic [31:0] chain_words [8];
  logic [7:0]  block_bytes [64];
  int unsigned block_fill;
  logic [60:0] msg_byte_cnt;

  digest_beat_t digest_q [$];
  digest_beat_t exp_beat;

  int unsigned err_cnt = 0;
  int unsigned quiet_cycles = 0;
  int unsigned beats_sent = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_req = 0;
  int unsigned hold_ack = 0;

  sha256_hash_engine i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .data_byte_i   (data_byte_i),
    .has_byte_i    (has_byte_i),
    .is_last_i     (is_last_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .digest_word_o (digest_word_o),
    .word_index_o  (word_index_o),
    .last_word_o   (last_word_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic logic [31:0] ror32(input logic [31:0] x, input int unsigned n);
    logic [63:0] dbl;
    dbl = {x, x} >> n;
    return dbl[31:0];
  endfunction

  function automatic void compress_block();
    logic [31:0] w [64];
    logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
    int unsigned r;
    for (r = 0; r < 16; r++) begin
      w[r] = {block_bytes[4*r], block_bytes[4*r+1], block_bytes[4*r+2], block_bytes[4*r+3]};
    end
    for (r = 16; r < 64; r++) begin
      s0 = ror32(w[r-15], 7) ^ ror32(w[r-15], 18) ^ (w[r-15] >> 3);
      s1 = ror32(w[r-2], 17) ^ ror32(w[r-2], 19) ^ (w[r-2] >> 10);
      w[r] = w[r-16] + s0 + w[r-7] + s1;
    end
    a = chain_words[0]; b = chain_words[1]; c = chain_words[2]; d = chain_words[3];
    e = chain_words[4]; f = chain_words[5]; g = chain_words[6]; h = chain_words[7];
    for (r = 0; r < 64; r++) begin
      t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g))
           + KWords[r] + w[r];
      t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1;
      d = c; c = b; b = a; a = t1 + t2;
    end
    chain_words[0] += a; chain_words[1] += b; chain_words[2] += c; chain_words[3] += d;
    chain_words[4] += e; chain_words[5] += f; chain_words[6] += g; chain_words[7] += h;
  endfunction

  function automatic void clear_message();
    chain_words = IvWords;
    block_fill = 0;
    msg_byte_cnt = '0;
  endfunction

  // absorb one accepted beat; a finishing beat queues the eight digest words
  function automatic void hash_absorb(input logic [7:0] b, input logic has, input logic last);
    logic [63:0] bit_len;
    int unsigned q;
    if (has) begin
      block_bytes[block_fill] = b;
      msg_byte_cnt = msg_byte_cnt + 61'd1;
      block_fill++;
      if (block_fill == 64) begin
        compress_block();
        block_fill = 0;
      end
    end
    if (!last) return;
    block_bytes[block_fill] = 8'h80;
    for (q = block_fill + 1; q < 64; q++) block_bytes[q] = 8'h00;
    // no room left for the length field, spill into a second block
    if (block_fill > 55) begin
      compress_block();
      for (q = 0; q < 56; q++) block_bytes[q] = 8'h00;
    end
    bit_len = {msg_byte_cnt, 3'b000};
    for (q = 0; q < 8; q++) block_bytes[63-q] = bit_len[8*q +: 8];
    compress_block();
    for (q = 0; q < 8; q++) begin
      digest_q.push_back('{word: chain_words[q], idx: 3'(q), last: (q == 7)});
    end
    clear_message();
  endfunction

  task automatic send_beat(input logic [7:0] b, input logic has, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    has_byte_i  <= has;
    is_last_i   <= last;
    do @(posedge clk_i); while (!in_ready_o);
    hash_absorb(b, has, last);
    if (has || last) beats_sent++;
  endtask

  // random content, the end mark either folded into the last byte beat or sent as a bare end beat
  task automatic send_message(input int unsigned len);
    logic fold;
    int unsigned i;
    fold = (len != 0) && ($urandom_range(1) == 1);
    for (i = 0; i < len; i++) begin
      if ($urandom_range(7) == 0) send_beat(8'($urandom), 1'b0, 1'b0);
      send_beat(8'($urandom), 1'b1, fold && (i == len - 1));
    end
    if (!fold) send_beat(8'($urandom), 1'b0, 1'b1);
  endtask

  task automatic test_directed();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    send_beat(8'h00, 1'b0, 1'b1);   // empty message
    send_beat(8'hff, 1'b0, 1'b0);   // ignored beat
    send_beat(8'h61, 1'b1, 1'b0);
    send_beat(8'h62, 1'b1, 1'b0);
    send_beat(8'h63, 1'b1, 1'b1);
    send_beat(8'h00, 1'b1, 1'b0);
    send_beat(8'hff, 1'b1, 1'b0);
    send_beat(8'h5a, 1'b0, 1'b0);
    send_beat(8'hff, 1'b0, 1'b1);
    send_beat(8'hff, 1'b1, 1'b1);
    send_beat(8'h00, 1'b1, 1'b1);
  endtask

  // tail lengths around the point where the length field no longer fits
  task automatic test_padding_edges();
    int unsigned lens [4] = '{55, 56, 63, 64};
    int unsigned k;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    for (k = 0; k < 4; k++) send_message(lens[k]);
  endtask

  task automatic test_idle_phases();
    int unsigned send_pct [4] = '{0, 74, 0, 12};
    int unsigned recv_pct [4] = '{0, 0, 74, 12};
    int unsigned p, mark;
    for (p = 0; p < 4; p++) begin
      send_idle_pct = send_pct[p];
      recv_stall_pct = recv_pct[p];
      mark = beats_sent;
      while (beats_sent - mark < 6) begin
        send_message($urandom_range(4));
      end
    end
  endtask

  // receiver holds off while messages keep coming, so the input side backs up
  task automatic test_output_hold();
    int unsigned k;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_req <= hold_req + 1;
    for (k = 0; k < 3; k++) send_message($urandom_range(3, 1));
  endtask

  initial begin : receiver
    forever begin
      @(posedge clk_i);
      if (hold_req != hold_ack) begin
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_ack <= hold_req;
      end
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (digest_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10) begin
          $display("unexpected digest beat: word %h index %0d last %b",
                   digest_word_o, word_index_o, last_word_o);
        end
      end else begin
        exp_beat = digest_q.pop_front();
        if (digest_word_o !== exp_beat.word || word_index_o !== exp_beat.idx ||
            last_word_o !== exp_beat.last) begin
          err_cnt++;
          if (err_cnt <= 10) begin
            $display("digest mismatch: exp word %h index %0d last %b,",
                     exp_beat.word, exp_beat.idx, exp_beat.last,
                     " got word %h index %0d last %b",
                     digest_word_o, word_index_o, last_word_o);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    clear_message();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_padding_edges();
    test_idle_phases();
    test_output_hold();
    in_valid_i <= 1'b0;
    while (digest_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
